@@ src/sva_pkg.sv @@
// Package for the synthesizer voice allocator.
// Holds the request and result types, status and sequencer codes and constants.
// No dependencies.
package sva_pkg;

  typedef enum logic [1:0] {
    V_OFF = 2'd0,
    V_ON  = 2'd1,
    V_SUS = 2'd2,
    V_REL = 2'd3
  } vstat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } seq_state_t;

  localparam logic [2:0] F_NOTE_ON    = 3'd0;
  localparam logic [2:0] F_NOTE_OFF   = 3'd1;
  localparam logic [2:0] F_PEDAL      = 3'd2;
  localparam logic [2:0] F_ALL_NOTES  = 3'd3;
  localparam logic [2:0] F_ALL_SOUNDS = 3'd4;
  localparam logic [2:0] F_VOICE_DONE = 3'd5;

  localparam logic REG_VOICE_LIMIT = 1'b0;
  localparam logic REG_MONO_MODE   = 1'b1;

  localparam logic [10:0] PRI_REL_DROP = 11'd2000;
  localparam logic [10:0] PRI_SUS_DROP = 11'd1000;
  localparam logic [6:0]  PEDAL_HELD_MIN = 7'd64;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] key;
    logic [6:0] velocity;
    logic [6:0] pedal_value;
    logic [3:0] done_voice;
  } in_req_t;

  typedef struct packed {
    logic [3:0] voice_index;
    logic       took_voice;
    logic       stolen;
    logic [6:0] start_velocity;
    logic [4:0] changed_count;
  } out_res_t;

endpackage

@@ src/synth_voice_allocator_top.sv @@
// Top level of the synthesizer voice allocator.
// Uses sva_pkg for the request and result types and the status codes.
//
// Usage: a request is taken on in_req at a clock edge where start is high and
// busy is low. Each request yields exactly one result on out_res, valid for one
// cycle while out_strobe is high; the receiver cannot stall it.
// A request walks the voices in use one per cycle through a single shared
// compare and priority unit. A scanning request keeps busy high for the whole
// walk and the S_DONE state; the strobe comes in the next cycle, which is
// also the first idle one, so a new request is taken only once the last one's
// result is out. Mono note on, an out-of-range voice done and unknown codes
// skip the walk; voice done looks at its one voice only.
// The voice walk runs in the S_SCAN state; busy stays high for the
// whole walk, and a new request may be taken at the edge that ends the strobe.
// Configuration writes on cfg_we, cfg_index and cfg_wdata take effect at once;
// the user must make them only while the block is idle (unchecked in the block).
// Reset clears every voice to off, the note counter, the pedal, and sets the
// voice limit to 16 in polyphonic mode.
module synth_voice_allocator_top
  import sva_pkg::*;
#(
  parameter int MAX_VOICES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_strobe,
  output out_res_t   out_res,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int NCAP = (MAX_VOICES < 16) ? MAX_VOICES : 16;
  localparam int VW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW   = (NCAP > 1) ? $clog2(NCAP) : 1;

  function automatic logic [4:0] voices_used(input logic [4:0] limit, input logic mono);
    logic [4:0] n;
    n = limit;
    if (mono) begin
      n = 5'd1;
    end else if (limit == 5'd0) begin
      n = 5'd1;
    end else if (limit > 5'(NCAP)) begin
      n = 5'(NCAP);
    end
    return n;
  endfunction

  seq_state_t state_r, state_nxt;
  in_req_t    req_r;
  logic [CW-1:0] scan_r;
  logic [4:0]    cnt_r;
  logic          free_found_r;
  logic [VW-1:0] free_idx_r;
  logic          best_valid_r;
  logic [32:0]   best_key_r;
  logic [VW-1:0] best_idx_r;
  logic          best_chg_r;
  logic [31:0]   counter_r;
  logic          pedal_r;
  logic [4:0]    limit_r;
  logic          mono_r;
  vstat_t        status_r [MAX_VOICES];
  logic [6:0]    key_r    [MAX_VOICES];
  logic [31:0]   nn_r     [MAX_VOICES];
  out_res_t      out_r;
  logic          out_strobe_r;

  logic [4:0]    n_use;
  logic [4:0]    n_cfg;
  logic          scan_last;
  logic          in_dv_in_range;
  logic [VW-1:0] addr;
  vstat_t        cur_st;
  vstat_t        new_st;
  logic [6:0]    cur_key;
  logic [31:0]   age;
  logic [10:0]   drop;
  logic [32:0]   pri_key;
  logic          is_note_on;
  logic [VW-1:0] start_idx;
  logic          steal;
  out_res_t      res_nxt;

  assign n_use          = voices_used(limit_r, mono_r);
  assign n_cfg          = voices_used(cfg_wdata, 1'b0);
  assign scan_last      = (scan_r == CW'(n_use - 5'd1));
  assign in_dv_in_range = (int'(in_req.done_voice) < MAX_VOICES);
  assign addr = (req_r.func == F_VOICE_DONE) ? VW'(req_r.done_voice) : VW'(scan_r);
  assign cur_st  = status_r[addr];
  assign cur_key = key_r[addr];
  assign age     = counter_r - nn_r[addr];
  assign drop    = (new_st == V_REL) ? PRI_REL_DROP :
                   (new_st == V_SUS) ? PRI_SUS_DROP : 11'd0;
  assign pri_key = {1'b0, age} + 33'(drop);

  always_comb begin
    new_st = cur_st;
    unique case (req_r.func)
      F_NOTE_ON: begin
        if (cur_key == req_r.key && (cur_st == V_ON || cur_st == V_SUS)) begin
          new_st = V_REL;
        end
      end
      F_NOTE_OFF: begin
        if (cur_st == V_ON && (mono_r || cur_key == req_r.key)) begin
          new_st = pedal_r ? V_SUS : V_REL;
        end
      end
      F_PEDAL: begin
        if (!pedal_r && cur_st == V_SUS) begin
          new_st = V_REL;
        end
      end
      F_ALL_NOTES: begin
        if (cur_st == V_ON || cur_st == V_SUS) begin
          new_st = V_REL;
        end
      end
      F_ALL_SOUNDS, F_VOICE_DONE: begin
        new_st = V_OFF;
      end
      default: begin
        new_st = cur_st;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if ((in_req.func == F_NOTE_ON && mono_r) ||
              (in_req.func == F_VOICE_DONE && !in_dv_in_range) ||
              (in_req.func > F_VOICE_DONE)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (req_r.func == F_VOICE_DONE || scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = (state_r != S_IDLE);
    is_note_on = (req_r.func == F_NOTE_ON);
    steal      = is_note_on && !mono_r && !free_found_r;
    if (mono_r) begin
      start_idx = '0;
    end else if (free_found_r) begin
      start_idx = free_idx_r;
    end else begin
      start_idx = best_idx_r;
    end
    res_nxt = '0;
    res_nxt.changed_count = cnt_r - {4'd0, steal & best_chg_r};
    if (is_note_on) begin
      res_nxt.voice_index    = 4'(start_idx);
      res_nxt.took_voice     = 1'b1;
      res_nxt.stolen         = steal;
      res_nxt.start_velocity = req_r.velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      counter_r    <= '0;
      pedal_r      <= 1'b0;
      limit_r      <= 5'd16;
      mono_r       <= 1'b0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        status_r[i] <= V_OFF;
        key_r[i]    <= '0;
        nn_r[i]     <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r        <= in_req;
            scan_r       <= '0;
            cnt_r        <= '0;
            free_found_r <= 1'b0;
            best_valid_r <= 1'b0;
            if (in_req.func == F_PEDAL) begin
              pedal_r <= (in_req.pedal_value >= PEDAL_HELD_MIN);
            end else if (in_req.func == F_ALL_NOTES) begin
              pedal_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          status_r[addr] <= new_st;
          scan_r         <= scan_r + CW'(1);
          if (new_st != cur_st) begin
            cnt_r <= cnt_r + 5'd1;
          end
          if (is_note_on) begin
            if (!free_found_r && new_st == V_OFF) begin
              free_found_r <= 1'b1;
              free_idx_r   <= addr;
            end
            if (!best_valid_r || pri_key > best_key_r) begin
              best_valid_r <= 1'b1;
              best_key_r   <= pri_key;
              best_idx_r   <= addr;
              best_chg_r   <= (new_st != cur_st);
            end
          end
        end
        S_DONE: begin
          out_r <= res_nxt;
          if (is_note_on) begin
            status_r[start_idx] <= V_ON;
            key_r[start_idx]    <= req_r.key;
            nn_r[start_idx]     <= counter_r;
            counter_r           <= counter_r + 32'd1;
          end
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        if (cfg_index == REG_VOICE_LIMIT) begin
          limit_r <= cfg_wdata;
          for (int i = 0; i < MAX_VOICES; i++) begin
            if (!mono_r && i >= int'(n_cfg)) begin
              status_r[i] <= V_OFF;
            end
          end
        end else begin
          mono_r <= cfg_wdata[0];
          for (int i = 0; i < MAX_VOICES; i++) begin
            if (cfg_wdata[0] && !mono_r) begin
              status_r[i] <= V_OFF;
            end
          end
        end
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

endmodule
